[sv/ldp_session_state_machine_top_macros.svh]
// assertion helpers shared by the session block
`ifndef LDP_SESSION_STATE_MACHINE_TOP_MACROS_SVH
`define LDP_SESSION_STATE_MACHINE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define LDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LDP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ldp_ssm_pkg.sv]
package ldp_ssm_pkg;

  // input modes
  localparam logic [1:0] MODE_MSG  = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_OPEN = 2'd2;
  localparam logic [1:0] MODE_FAIL = 2'd3;

  // message types
  localparam logic [1:0] MT_INIT      = 2'd0;
  localparam logic [1:0] MT_KEEPALIVE = 2'd1;

  // session states
  localparam logic [2:0] ST_INVALID  = 3'd0;
  localparam logic [2:0] ST_INIT     = 3'd1;
  localparam logic [2:0] ST_OPENREC  = 3'd2;
  localparam logic [2:0] ST_OPENSENT = 3'd3;
  localparam logic [2:0] ST_OPER     = 3'd4;

  // notification status codes
  localparam logic [2:0] SC_SHUTDOWN  = 3'd0;
  localparam logic [2:0] SC_INTERNAL  = 3'd1;
  localparam logic [2:0] SC_MISSING   = 3'd2;
  localparam logic [2:0] SC_MALFORMED = 3'd3;
  localparam logic [2:0] SC_BAD_KA    = 3'd4;
  localparam logic [2:0] SC_REJECTED  = 3'd5;
  localparam logic [2:0] SC_EXPIRED   = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_ROUTER_ID   = 2'd0;
  localparam logic [1:0] CFG_LABEL_SPACE = 2'd1;
  localparam logic [1:0] CFG_KEEPALIVE   = 2'd2;

  localparam logic [15:0] KA_RESET  = 16'd180;
  localparam logic [15:0] KA_MARGIN = 16'd10;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  msg_type;
    logic [31:0] msg_id;
    logic        has_session_tlv;
    logic        tlv_value_ok;
    logic        loop_detect;
    logic [15:0] peer_keepalive;
    logic [31:0] receiver_router_id;
    logic [15:0] receiver_label_space;
    logic [31:0] sender_router_id;
    logic [15:0] sender_label_space;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic        send_init;
    logic        send_keepalive;
    logic        send_notification;
    logic [2:0]  status_code;
    logic [31:0] ref_msg_id;
    logic        ref_session_tlv;
    logic        deliver_message;
    logic        session_up;
    logic        request_shutdown;
    logic [2:0]  session_state;
    logic [31:0] init_receiver_router_id;
    logic [15:0] init_receiver_label_space;
  } result_t;

  typedef struct packed {
    logic [2:0]  state;
    logic [31:0] nbr_router_id;
    logic [15:0] nbr_label_space;
    logic [15:0] neg_keepalive;
    logic [31:0] last_send_time;
    logic [31:0] last_recv_time;
  } sess_t;

  typedef struct packed {
    logic [31:0] router_id;
    logic [15:0] label_space;
  } local_cfg_t;

endpackage

[sv/ldp_ssm_step.sv]
module ldp_ssm_step (
  input  ldp_ssm_pkg::item_t      item,
  input  ldp_ssm_pkg::sess_t      sess,
  input  ldp_ssm_pkg::local_cfg_t lcfg,
  output ldp_ssm_pkg::sess_t      sess_nxt,
  output ldp_ssm_pkg::result_t    res
);
  import ldp_ssm_pkg::*;

  logic        chk_fail;
  logic        chk_negotiate;
  logic [2:0]  chk_code;
  logic        chk_tlv;
  logic [15:0] ka_min;
  logic [15:0] ka_thresh;
  logic [31:0] since_send;
  logic [31:0] since_recv;
  logic        sent;

  // init parameter checks, first failure wins
  always_comb begin
    chk_fail      = 1'b1;
    chk_negotiate = 1'b0;
    chk_code      = SC_SHUTDOWN;
    chk_tlv       = 1'b0;
    if (!item.has_session_tlv) begin
      chk_code = SC_MISSING;
    end else if (!item.tlv_value_ok) begin
      chk_code = SC_MALFORMED;
    end else if (item.loop_detect) begin
      chk_code = SC_INTERNAL;
      chk_tlv  = 1'b1;
    end else if (item.peer_keepalive == 16'd0) begin
      chk_code = SC_BAD_KA;
      chk_tlv  = 1'b1;
    end else begin
      chk_negotiate = 1'b1;
      if (item.receiver_router_id != lcfg.router_id ||
          item.receiver_label_space != lcfg.label_space) begin
        chk_code = SC_REJECTED;
      end else begin
        chk_fail = 1'b0;
      end
    end
  end

  assign ka_min     = (sess.neg_keepalive > item.peer_keepalive) ? item.peer_keepalive
                                                                 : sess.neg_keepalive;
  assign ka_thresh  = (sess.neg_keepalive > KA_MARGIN) ? sess.neg_keepalive - KA_MARGIN
                                                       : 16'd0;
  assign since_send = item.now - sess.last_send_time;
  assign since_recv = item.now - sess.last_recv_time;

  always_comb begin
    sess_nxt = sess;
    res      = '0;
    sent     = 1'b0;
    case (item.mode)
      MODE_FAIL: begin
        sess_nxt.last_recv_time = item.now;
        sess_nxt.state          = ST_INVALID;
        res.send_notification   = 1'b1;
        res.status_code         = SC_SHUTDOWN;
        sent                    = 1'b1;
      end
      MODE_OPEN: begin
        sess_nxt.nbr_router_id   = item.sender_router_id;
        sess_nxt.nbr_label_space = item.sender_label_space;
        if (sess.state == ST_INIT) begin
          res.send_init                 = 1'b1;
          res.init_receiver_router_id   = item.sender_router_id;
          res.init_receiver_label_space = item.sender_label_space;
          sess_nxt.state                = ST_OPENSENT;
          sent                          = 1'b1;
        end
      end
      MODE_TICK: begin
        if (sess.state == ST_OPER) begin
          if (since_send > {16'd0, ka_thresh}) begin
            res.send_keepalive = 1'b1;
            sent               = 1'b1;
          end
          if (since_recv > {16'd0, sess.neg_keepalive}) begin
            res.request_shutdown = 1'b1;
            res.status_code      = SC_EXPIRED;
          end
        end
      end
      default: begin
        sess_nxt.last_recv_time = item.now;
        case (sess.state)
          ST_INVALID: begin
          end
          ST_INIT, ST_OPENSENT: begin
            sent = 1'b1;
            if (item.msg_type != MT_INIT) begin
              sess_nxt.state        = ST_INVALID;
              res.send_notification = 1'b1;
              res.status_code       = SC_SHUTDOWN;
            end else begin
              // only a fresh init from the initialized state learns the neighbor
              if (sess.state == ST_INIT) begin
                sess_nxt.nbr_router_id   = item.sender_router_id;
                sess_nxt.nbr_label_space = item.sender_label_space;
              end
              if (chk_negotiate) begin
                sess_nxt.neg_keepalive = ka_min;
              end
              if (chk_fail) begin
                sess_nxt.state        = ST_INVALID;
                res.send_notification = 1'b1;
                res.status_code       = chk_code;
                res.ref_msg_id        = item.msg_id;
                res.ref_session_tlv   = chk_tlv;
              end else begin
                res.send_keepalive = 1'b1;
                sess_nxt.state     = ST_OPENREC;
                if (sess.state == ST_INIT) begin
                  res.send_init                 = 1'b1;
                  res.init_receiver_router_id   = item.sender_router_id;
                  res.init_receiver_label_space = item.sender_label_space;
                end
              end
            end
          end
          ST_OPENREC: begin
            if (item.msg_type != MT_KEEPALIVE) begin
              sess_nxt.state        = ST_INVALID;
              res.send_notification = 1'b1;
              res.status_code       = SC_SHUTDOWN;
              sent                  = 1'b1;
            end else begin
              res.session_up = 1'b1;
              sess_nxt.state = ST_OPER;
            end
          end
          ST_OPER: begin
            res.deliver_message = (item.msg_type != MT_KEEPALIVE);
          end
          default: begin
            res.send_notification = 1'b1;
            res.status_code       = SC_INTERNAL;
            sent                  = 1'b1;
          end
        endcase
      end
    endcase
    if (sent) begin
      sess_nxt.last_send_time = item.now;
    end
    res.session_state = sess_nxt.state;
  end

endmodule

[sv/ldp_session_state_machine_top.sv]
// pipeline: an accepted item lands in the input register, and its result loads into the result
// register when that register is free or draining (out_vld low or out_stall low)
// throughput: one item per cycle while out_stall is low; the session update is combinational
// logic between the two registers, and the next item sees the updated session state directly
// reset (synchronous, rst_n low): state initialized, neighbor and timers zero, negotiated
// keepalive 180, local router id and label space zero, both pipeline registers empty
module ldp_session_state_machine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  input  logic        in_vld,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_msg_type,
  input  logic [31:0] in_msg_id,
  input  logic        in_has_session_tlv,
  input  logic        in_tlv_value_ok,
  input  logic        in_loop_detect,
  input  logic [15:0] in_peer_keepalive,
  input  logic [31:0] in_receiver_router_id,
  input  logic [15:0] in_receiver_label_space,
  input  logic [31:0] in_sender_router_id,
  input  logic [15:0] in_sender_label_space,
  input  logic [31:0] in_now,
  output logic        out_vld,
  input  logic        out_stall,
  output logic        out_send_init,
  output logic        out_send_keepalive,
  output logic        out_send_notification,
  output logic [2:0]  out_status_code,
  output logic [31:0] out_ref_msg_id,
  output logic        out_ref_session_tlv,
  output logic        out_deliver_message,
  output logic        out_session_up,
  output logic        out_request_shutdown,
  output logic [2:0]  out_session_state,
  output logic [31:0] out_init_receiver_router_id,
  output logic [15:0] out_init_receiver_label_space
);
  import ldp_ssm_pkg::*;

  `include "ldp_session_state_machine_top_macros.svh"

  logic       in_vld_r;
  item_t      item_r;
  logic       out_vld_r;
  result_t    out_r;
  sess_t      sess_r;
  sess_t      sess_nxt;
  result_t    res;
  local_cfg_t lcfg_r;
  logic       adv;
  logic       in_acc;

  // result register free or draining this cycle
  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_vld && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.mode                 <= in_mode;
      item_r.msg_type             <= in_msg_type;
      item_r.msg_id               <= in_msg_id;
      item_r.has_session_tlv      <= in_has_session_tlv;
      item_r.tlv_value_ok         <= in_tlv_value_ok;
      item_r.loop_detect          <= in_loop_detect;
      item_r.peer_keepalive       <= in_peer_keepalive;
      item_r.receiver_router_id   <= in_receiver_router_id;
      item_r.receiver_label_space <= in_receiver_label_space;
      item_r.sender_router_id     <= in_sender_router_id;
      item_r.sender_label_space   <= in_sender_label_space;
      item_r.now                  <= in_now;
    end
  end

  ldp_ssm_step u_step (
    .item     (item_r),
    .sess     (sess_r),
    .lcfg     (lcfg_r),
    .sess_nxt (sess_nxt),
    .res      (res)
  );

  // session state and local configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sess_r.state           <= ST_INIT;
      sess_r.nbr_router_id   <= '0;
      sess_r.nbr_label_space <= '0;
      sess_r.neg_keepalive   <= KA_RESET;
      sess_r.last_send_time  <= '0;
      sess_r.last_recv_time  <= '0;
      lcfg_r.router_id       <= '0;
      lcfg_r.label_space     <= '0;
    end else begin
      if (in_vld_r && adv) begin
        sess_r <= sess_nxt;
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ROUTER_ID:   lcfg_r.router_id <= cfg_data;
          CFG_LABEL_SPACE: lcfg_r.label_space <= cfg_data[15:0];
          CFG_KEEPALIVE:   sess_r.neg_keepalive <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r && adv) begin
      out_r <= res;
    end
  end

  assign out_vld                       = out_vld_r;
  assign out_send_init                 = out_r.send_init;
  assign out_send_keepalive            = out_r.send_keepalive;
  assign out_send_notification         = out_r.send_notification;
  assign out_status_code               = out_r.status_code;
  assign out_ref_msg_id                = out_r.ref_msg_id;
  assign out_ref_session_tlv           = out_r.ref_session_tlv;
  assign out_deliver_message           = out_r.deliver_message;
  assign out_session_up                = out_r.session_up;
  assign out_request_shutdown          = out_r.request_shutdown;
  assign out_session_state             = out_r.session_state;
  assign out_init_receiver_router_id   = out_r.init_receiver_router_id;
  assign out_init_receiver_label_space = out_r.init_receiver_label_space;

  `LDP_ASSERT_NOW(a_up_is_oper, out_vld_r && out_r.session_up, out_r.session_state == ST_OPER, "session up without operational state")
  `LDP_ASSERT_NOW(a_expiry_code, out_vld_r && out_r.request_shutdown, out_r.status_code == SC_EXPIRED && !out_r.send_notification, "hold expiry with wrong status")
  `LDP_ASSERT_NOW(a_state_range, 1'b1, sess_r.state <= ST_OPER, "session state out of range")
  `LDP_ASSERT_NXT(a_item_held, in_vld_r && !adv, in_vld_r && out_vld_r, "pending item lost while result blocked")

endmodule

[test/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ldp_ssm_pkg::*;

  localparam logic [1:0] MT_OTHER   = 2'd2;
  localparam logic [1:0] MT_UNKNOWN = 2'd3;
  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 80;

  // session predictor and the replies it still waits for
  class session_scoreboard;
    logic [31:0] loc_id;
    logic [15:0] loc_ls;
    logic [15:0] loc_ka;
    logic [2:0]  state;
    logic [31:0] nbr_id;
    logic [15:0] nbr_ls;
    logic [15:0] neg_ka;
    logic [31:0] last_send;
    logic [31:0] last_recv;
    result_t     pending[$];
    int mismatches;
    int n_events, n_replies, n_up, n_delivered, n_keepalive, n_shutdown, n_notice;

    function new();
      loc_id = '0;
      loc_ls = '0;
      loc_ka = KA_RESET;
      state = ST_INIT;
      nbr_id = '0;
      nbr_ls = '0;
      neg_ka = KA_RESET;
      last_send = '0;
      last_recv = '0;
      mismatches = 0;
    endfunction

    function void cfg_write(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_ROUTER_ID: loc_id = val;
        CFG_LABEL_SPACE: loc_ls = val[15:0];
        CFG_KEEPALIVE: begin
          loc_ka = val[15:0];
          neg_ka = val[15:0];
        end
        default: ;
      endcase
    endfunction

    function logic [15:0] ka_threshold();
      return (neg_ka > KA_MARGIN) ? neg_ka - KA_MARGIN : 16'd0;
    endfunction

    function void notice(inout result_t r, input logic [2:0] code, input logic [31:0] id,
                         input logic tlv);
      r.send_notification = 1'b1;
      r.status_code = code;
      r.ref_msg_id = id;
      r.ref_session_tlv = tlv;
    endfunction

    // peer init parameter checks, in protocol order
    function bit init_ok(item_t ev, inout result_t r);
      if (!ev.has_session_tlv) begin
        notice(r, SC_MISSING, ev.msg_id, 1'b0);
        return 1'b0;
      end
      if (!ev.tlv_value_ok) begin
        notice(r, SC_MALFORMED, ev.msg_id, 1'b0);
        return 1'b0;
      end
      if (ev.loop_detect) begin
        notice(r, SC_INTERNAL, ev.msg_id, 1'b1);
        return 1'b0;
      end
      if (ev.peer_keepalive == 16'd0) begin
        notice(r, SC_BAD_KA, ev.msg_id, 1'b1);
        return 1'b0;
      end
      // keepalive is negotiated down even if the receiver check fails
      if (neg_ka > ev.peer_keepalive) neg_ka = ev.peer_keepalive;
      if (ev.receiver_router_id != loc_id || ev.receiver_label_space != loc_ls) begin
        notice(r, SC_REJECTED, ev.msg_id, 1'b0);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_event(item_t ev);
      result_t r;
      logic sent;
      r = '0;
      sent = 1'b0;
      case (ev.mode)
        MODE_FAIL: begin
          last_recv = ev.now;
          state = ST_INVALID;
          notice(r, SC_SHUTDOWN, '0, 1'b0);
          sent = 1'b1;
        end
        MODE_OPEN: begin
          nbr_id = ev.sender_router_id;
          nbr_ls = ev.sender_label_space;
          if (state == ST_INIT) begin
            r.send_init = 1'b1;
            r.init_receiver_router_id = nbr_id;
            r.init_receiver_label_space = nbr_ls;
            state = ST_OPENSENT;
            sent = 1'b1;
          end
        end
        MODE_TICK: begin
          if (state == ST_OPER) begin
            if (ev.now - last_send > {16'd0, ka_threshold()}) begin
              r.send_keepalive = 1'b1;
              sent = 1'b1;
            end
            if (ev.now - last_recv > {16'd0, neg_ka}) begin
              r.request_shutdown = 1'b1;
              r.status_code = SC_EXPIRED;
            end
          end
        end
        default: begin
          last_recv = ev.now;
          case (state)
            ST_INVALID: ;
            ST_INIT: begin
              sent = 1'b1;
              if (ev.msg_type != MT_INIT) begin
                state = ST_INVALID;
                notice(r, SC_SHUTDOWN, '0, 1'b0);
              end else begin
                nbr_id = ev.sender_router_id;
                nbr_ls = ev.sender_label_space;
                if (!init_ok(ev, r)) begin
                  state = ST_INVALID;
                end else begin
                  r.send_init = 1'b1;
                  r.send_keepalive = 1'b1;
                  r.init_receiver_router_id = nbr_id;
                  r.init_receiver_label_space = nbr_ls;
                  state = ST_OPENREC;
                end
              end
            end
            ST_OPENREC: begin
              if (ev.msg_type != MT_KEEPALIVE) begin
                state = ST_INVALID;
                notice(r, SC_SHUTDOWN, '0, 1'b0);
                sent = 1'b1;
              end else begin
                r.session_up = 1'b1;
                state = ST_OPER;
              end
            end
            ST_OPENSENT: begin
              sent = 1'b1;
              if (ev.msg_type != MT_INIT) begin
                state = ST_INVALID;
                notice(r, SC_SHUTDOWN, '0, 1'b0);
              end else if (!init_ok(ev, r)) begin
                state = ST_INVALID;
              end else begin
                r.send_keepalive = 1'b1;
                state = ST_OPENREC;
              end
            end
            ST_OPER: begin
              if (ev.msg_type != MT_KEEPALIVE) r.deliver_message = 1'b1;
            end
            default: begin
              notice(r, SC_INTERNAL, '0, 1'b0);
              sent = 1'b1;
            end
          endcase
        end
      endcase
      if (sent) last_send = ev.now;
      r.session_state = state;
      pending.push_back(r);
      n_events++;
      n_up += r.session_up;
      n_delivered += r.deliver_message;
      n_keepalive += r.send_keepalive;
      n_shutdown += r.request_shutdown;
      n_notice += r.send_notification;
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("result beat with no expected result waiting");
        mismatches++;
        return;
      end
      want = pending.pop_front();
      n_replies++;
      cmp("send_init", want.send_init, got.send_init);
      cmp("send_keepalive", want.send_keepalive, got.send_keepalive);
      cmp("send_notification", want.send_notification, got.send_notification);
      cmp("status_code", want.status_code, got.status_code);
      cmp("ref_msg_id", want.ref_msg_id, got.ref_msg_id);
      cmp("ref_session_tlv", want.ref_session_tlv, got.ref_session_tlv);
      cmp("deliver_message", want.deliver_message, got.deliver_message);
      cmp("session_up", want.session_up, got.session_up);
      cmp("request_shutdown", want.request_shutdown, got.request_shutdown);
      cmp("session_state", want.session_state, got.session_state);
      cmp("init_receiver_router_id", want.init_receiver_router_id,
          got.init_receiver_router_id);
      cmp("init_receiver_label_space", want.init_receiver_label_space,
          got.init_receiver_label_space);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;
  logic        in_vld;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [1:0]  in_msg_type;
  logic [31:0] in_msg_id;
  logic        in_has_session_tlv;
  logic        in_tlv_value_ok;
  logic        in_loop_detect;
  logic [15:0] in_peer_keepalive;
  logic [31:0] in_receiver_router_id;
  logic [15:0] in_receiver_label_space;
  logic [31:0] in_sender_router_id;
  logic [15:0] in_sender_label_space;
  logic [31:0] in_now;
  logic        out_vld;
  logic        out_stall;
  logic        out_send_init;
  logic        out_send_keepalive;
  logic        out_send_notification;
  logic [2:0]  out_status_code;
  logic [31:0] out_ref_msg_id;
  logic        out_ref_session_tlv;
  logic        out_deliver_message;
  logic        out_session_up;
  logic        out_request_shutdown;
  logic [2:0]  out_session_state;
  logic [31:0] out_init_receiver_router_id;
  logic [15:0] out_init_receiver_label_space;

  session_scoreboard sb;
  logic [31:0] wall;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_off_req = 1'b0;
  int tx_rush = 0;
  int quiet = 0;
  int n_cfg = 0;

  ldp_session_state_machine_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data),
    .in_vld(in_vld),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_msg_type(in_msg_type),
    .in_msg_id(in_msg_id),
    .in_has_session_tlv(in_has_session_tlv),
    .in_tlv_value_ok(in_tlv_value_ok),
    .in_loop_detect(in_loop_detect),
    .in_peer_keepalive(in_peer_keepalive),
    .in_receiver_router_id(in_receiver_router_id),
    .in_receiver_label_space(in_receiver_label_space),
    .in_sender_router_id(in_sender_router_id),
    .in_sender_label_space(in_sender_label_space),
    .in_now(in_now),
    .out_vld(out_vld),
    .out_stall(out_stall),
    .out_send_init(out_send_init),
    .out_send_keepalive(out_send_keepalive),
    .out_send_notification(out_send_notification),
    .out_status_code(out_status_code),
    .out_ref_msg_id(out_ref_msg_id),
    .out_ref_session_tlv(out_ref_session_tlv),
    .out_deliver_message(out_deliver_message),
    .out_session_up(out_session_up),
    .out_request_shutdown(out_request_shutdown),
    .out_session_state(out_session_state),
    .out_init_receiver_router_id(out_init_receiver_router_id),
    .out_init_receiver_label_space(out_init_receiver_label_space)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // session clock in seconds, mostly small steps so the timers come due
  function automatic logic [31:0] next_now();
    if ($urandom_range(0, 39) == 0) wall = $urandom;
    else wall = wall + 32'($urandom_range(0, int'(sb.neg_ka) / 2 + 3));
    return wall;
  endfunction

  function automatic item_t noise_item();
    item_t ev;
    ev.mode = 2'($urandom_range(0, 3));
    ev.msg_type = 2'($urandom_range(0, 3));
    ev.msg_id = $urandom;
    ev.has_session_tlv = 1'($urandom);
    ev.tlv_value_ok = 1'($urandom);
    ev.loop_detect = 1'($urandom);
    ev.peer_keepalive = 16'($urandom);
    ev.receiver_router_id = $urandom;
    ev.receiver_label_space = 16'($urandom);
    ev.sender_router_id = $urandom;
    ev.sender_label_space = 16'($urandom);
    ev.now = $urandom;
    return ev;
  endfunction

  function automatic item_t shaped(logic [1:0] mode, logic [1:0] mt);
    item_t ev;
    ev = noise_item();
    ev.mode = mode;
    ev.msg_type = mt;
    ev.now = next_now();
    return ev;
  endfunction

  function automatic item_t good_init(logic [15:0] peer_ka);
    item_t ev;
    ev = shaped(MODE_MSG, MT_INIT);
    ev.has_session_tlv = 1'b1;
    ev.tlv_value_ok = 1'b1;
    ev.loop_detect = 1'b0;
    ev.peer_keepalive = peer_ka;
    ev.receiver_router_id = sb.loc_id;
    ev.receiver_label_space = sb.loc_ls;
    return ev;
  endfunction

  function automatic item_t oper_item();
    item_t ev;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) ev = shaped(MODE_TICK, 2'($urandom_range(0, 3)));
    else if (pick < 85) ev = shaped(MODE_MSG, 2'($urandom_range(0, 3)));
    else ev = shaped(MODE_OPEN, 2'($urandom_range(0, 3)));
    return ev;
  endfunction

  task automatic send_event(item_t ev);
    int gap;
    if (tx_rush > 0) begin
      gap = 0;
      tx_rush--;
    end else begin
      gap = tx_idle ? $urandom_range(0, 11) : 0;
    end
    if ($urandom_range(0, 29) == 0) tx_idle = !tx_idle;
    if (gap > 0) begin
      @(negedge clk);
      in_vld = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_mode = ev.mode;
    in_msg_type = ev.msg_type;
    in_msg_id = ev.msg_id;
    in_has_session_tlv = ev.has_session_tlv;
    in_tlv_value_ok = ev.tlv_value_ok;
    in_loop_detect = ev.loop_detect;
    in_peer_keepalive = ev.peer_keepalive;
    in_receiver_router_id = ev.receiver_router_id;
    in_receiver_label_space = ev.receiver_label_space;
    in_sender_router_id = ev.sender_router_id;
    in_sender_label_space = ev.sender_label_space;
    in_now = ev.now;
    in_vld = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_event(ev);
  endtask

  task automatic tick_at(logic [31:0] t);
    item_t ev;
    ev = shaped(MODE_TICK, MT_OTHER);
    ev.now = t;
    wall = t;
    send_event(ev);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_vld = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.cfg_write(idx, val);
    n_cfg++;
  endtask

  // result side: random stall per beat, one long hold-off on request
  initial begin
    int hold;
    result_t got;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_OFF_CYCLES;
      end else begin
        hold = rx_idle ? $urandom_range(0, 11) : 0;
      end
      if ($urandom_range(0, 29) == 0) rx_idle = !rx_idle;
      if (hold > 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_vld);
      got.send_init = out_send_init;
      got.send_keepalive = out_send_keepalive;
      got.send_notification = out_send_notification;
      got.status_code = out_status_code;
      got.ref_msg_id = out_ref_msg_id;
      got.ref_session_tlv = out_ref_session_tlv;
      got.deliver_message = out_deliver_message;
      got.session_up = out_session_up;
      got.request_shutdown = out_request_shutdown;
      got.session_state = out_session_state;
      got.init_receiver_router_id = out_init_receiver_router_id;
      got.init_receiver_label_space = out_init_receiver_label_space;
      sb.check_reply(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_vld && !in_stall) || (out_vld && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    item_t ev;
    logic [15:0] thr;
    logic [15:0] ka_plan [8];
    int p;
    int k;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_vld = 1'b0;
    in_mode = '0;
    in_msg_type = '0;
    in_msg_id = '0;
    in_has_session_tlv = 1'b0;
    in_tlv_value_ok = 1'b0;
    in_loop_detect = 1'b0;
    in_peer_keepalive = '0;
    in_receiver_router_id = '0;
    in_receiver_label_space = '0;
    in_sender_router_id = '0;
    in_sender_label_space = '0;
    in_now = '0;
    wall = $urandom;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    cfg_write(CFG_ROUTER_ID, $urandom);
    cfg_write(CFG_LABEL_SPACE, 32'($urandom_range(1, 65534)));
    cfg_write(CFG_KEEPALIVE, 32'd40);

    // handshake up to operational, by either side opening first
    send_event(shaped(MODE_TICK, MT_OTHER));
    if ($urandom_range(0, 1) == 1) begin
      ev = shaped(MODE_OPEN, MT_OTHER);
      ev.sender_router_id = '1;
      ev.sender_label_space = '1;
      send_event(ev);
      send_event(shaped(MODE_TICK, MT_OTHER));
      ev = good_init(16'($urandom_range(15, 30)));
      ev.msg_id = '1;
      send_event(ev);
    end else begin
      ev = good_init(16'hFFFF);
      ev.msg_id = '0;
      send_event(ev);
    end
    send_event(shaped(MODE_TICK, MT_OTHER));
    send_event(shaped(MODE_OPEN, MT_OTHER));
    send_event(shaped(MODE_MSG, MT_KEEPALIVE));

    // operational: every message type, then the timer boundaries
    send_event(shaped(MODE_MSG, MT_INIT));
    send_event(shaped(MODE_MSG, MT_KEEPALIVE));
    send_event(shaped(MODE_MSG, MT_OTHER));
    send_event(shaped(MODE_MSG, MT_UNKNOWN));
    send_event(shaped(MODE_OPEN, MT_INIT));
    thr = sb.ka_threshold();
    tick_at(sb.last_send + 32'(thr));
    tick_at(sb.last_send + 32'(thr) + 32'd1);
    send_event(shaped(MODE_MSG, MT_KEEPALIVE));
    tick_at(sb.last_recv + 32'(sb.neg_ka));
    tick_at(sb.last_recv + 32'(sb.neg_ka) + 32'd1);
    tick_at(sb.last_recv + 32'(sb.neg_ka) + 32'd100000);
    ev = '0;
    ev.mode = MODE_MSG;
    ev.now = next_now();
    send_event(ev);
    ev = '1;
    ev.mode = MODE_OPEN;
    ev.now = next_now();
    send_event(ev);

    ka_plan[0] = 16'd1;
    ka_plan[1] = 16'hFFFF;
    ka_plan[2] = 16'd10;
    ka_plan[3] = 16'd11;
    ka_plan[4] = 16'($urandom_range(1, 60));
    ka_plan[5] = 16'($urandom_range(1, 65535));
    ka_plan[6] = 16'd20;
    ka_plan[7] = 16'($urandom_range(12, 300));
    for (p = 0; p < 8; p++) begin
      wait_drain();
      cfg_write(CFG_ROUTER_ID, (p % 3 == 0) ? 32'd0 : (p % 3 == 1) ? '1 : $urandom);
      cfg_write(CFG_LABEL_SPACE, (p % 3 == 1) ? 32'd0 : (p % 3 == 2) ? 32'hFFFF :
                32'($urandom_range(0, 65535)));
      cfg_write(CFG_KEEPALIVE, 32'(ka_plan[p]));
      if (p == 2) begin
        // back-to-back beats against a held-off result side
        hold_off_req = 1'b1;
        tx_rush = 40;
      end
      if (p == 3) wall = 32'hFFFF_FFF8;
      for (k = 0; k < 215; k++) begin
        if (p == 5 && k == 100) wait_drain();
        send_event(oper_item());
      end
    end

    // parse failure ends the session, later events must leave it invalid
    wait_drain();
    send_event(shaped(MODE_FAIL, MT_OTHER));
    for (k = 0; k < 12; k++) begin
      ev = noise_item();
      ev.now = next_now();
      send_event(ev);
    end
    wait_drain();
    repeat (16) @(posedge clk);

    $display("covered %0d events, %0d results checked, %0d register writes",
             sb.n_events, sb.n_replies, n_cfg);
    $display("sessions up %0d, delivered %0d, keepalives %0d, expiries %0d, notices %0d",
             sb.n_up, sb.n_delivered, sb.n_keepalive, sb.n_shutdown, sb.n_notice);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
